>>> src/pss_pkg.sv
// Shared defaults for the previous-smaller-value stack block.
package pss_pkg;

  localparam int unsigned DEF_STACK_DEPTH = 64;
  localparam int unsigned DEF_VALUE_WIDTH = 32;

endpackage

>>> src/pss_if.sv
// Valid/ready item channels for the input samples and the results.
interface pss_in_if #(
  parameter int unsigned VALUE_WIDTH = pss_pkg::DEF_VALUE_WIDTH
);
  logic                          valid;
  logic                          ready;
  logic signed [VALUE_WIDTH-1:0] sample_value;
  logic                          end_of_sequence;

  modport source (output valid, output sample_value, output end_of_sequence, input ready);
  modport sink   (input valid, input sample_value, input end_of_sequence, output ready);
endinterface

interface pss_out_if #(
  parameter int unsigned VALUE_WIDTH = pss_pkg::DEF_VALUE_WIDTH
);
  logic                          valid;
  logic                          ready;
  logic signed [VALUE_WIDTH-1:0] smaller_value;
  logic                          found;
  logic                          overflowed;
  logic                          last_out;

  modport source (output valid, output smaller_value, output found, output overflowed,
                  output last_out, input ready);
  modport sink   (input valid, input smaller_value, input found, input overflowed,
                  input last_out, output ready);
endinterface

>>> src/pss_ram.sv
// Generic single-write, single-read RAM with registered read data.
module pss_ram #(
  parameter int unsigned WIDTH = pss_pkg::DEF_VALUE_WIDTH,
  parameter int unsigned DEPTH = pss_pkg::DEF_STACK_DEPTH,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> src/previous_smaller_stack_top.sv
// Top level of the previous-smaller-value monotonic stack.
//
// Each input item carries a signed sample; each result item gives the nearest
// earlier sample of the current sequence that is strictly smaller (found = 1),
// or all ones with found = 0 when there is none. Samples live in a circular
// buffer in RAM (STACK_DEPTH entries); the top entry is also held in a
// register, so a pop costs one RAM read and one compare. An item is accepted
// while the sequencer is idle; the shared compare unit then checks it once per
// popped entry, plus a final compare that pushes the sample and loads the
// output register. Over a long sequence each sample is popped at most once.
// in_item.ready is high only while the sequencer is idle; a finished result
// waits in the output register while the next item is taken, and the final
// compare step holds while that register is still occupied. A push onto a
// full stack advances the oldest-entry pointer instead of moving data, and
// flags overflowed. An item with end_of_sequence empties the stack after its
// result. No clearing pass follows reset: only entries below the count are
// ever read.
module previous_smaller_stack_top #(
  parameter int unsigned STACK_DEPTH = pss_pkg::DEF_STACK_DEPTH,
  parameter int unsigned VALUE_WIDTH = pss_pkg::DEF_VALUE_WIDTH
) (
  input  logic       clk,
  input  logic       rst_n,
  pss_in_if.sink     in_item,
  pss_out_if.source  out_item
);

  localparam int unsigned AW = $clog2(STACK_DEPTH);
  localparam int unsigned CW = $clog2(STACK_DEPTH + 1);
  localparam logic [AW-1:0] LAST_IDX = AW'(STACK_DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(STACK_DEPTH);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_CMP  = 2'b10
  } state_t;

  state_t                        state_r, state_nxt;
  logic [CW-1:0]                 count_r, count_nxt;
  logic [AW-1:0]                 base_r, base_nxt;
  logic [AW-1:0]                 top_ptr_r, top_ptr_nxt;
  logic signed [VALUE_WIDTH-1:0] top_val_r, top_val_nxt;
  logic                          pend_r, pend_nxt;
  logic signed [VALUE_WIDTH-1:0] sample_r, sample_nxt;
  logic                          last_r, last_nxt;

  logic                          out_valid_r, out_valid_nxt;
  logic signed [VALUE_WIDTH-1:0] out_value_r, out_value_nxt;
  logic                          out_found_r, out_found_nxt;
  logic                          out_ovf_r, out_ovf_nxt;
  logic                          out_last_r, out_last_nxt;

  logic                          ram_wr_en, ram_rd_en;
  logic [AW-1:0]                 ram_wr_addr, ram_rd_addr;
  logic [VALUE_WIDTH-1:0]        ram_rd_data;

  logic signed [VALUE_WIDTH-1:0] cmp_val;
  logic                          stack_nonempty, stack_full, do_pop, out_free;
  logic [AW-1:0]                 top_dec, top_inc, base_inc, push_addr;
  logic [CW-1:0]                 count_dec;

  pss_ram #(
    .WIDTH (VALUE_WIDTH),
    .DEPTH (STACK_DEPTH)
  ) u_stack_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (sample_r),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  // Circular pointer steps with wrap at the buffer end.
  assign top_dec  = (top_ptr_r == '0) ? LAST_IDX : top_ptr_r - AW'(1);
  assign top_inc  = (top_ptr_r == LAST_IDX) ? '0 : top_ptr_r + AW'(1);
  assign base_inc = (base_r == LAST_IDX) ? '0 : base_r + AW'(1);

  // Take the top fresh from RAM right after a pop, else from its register.
  assign cmp_val        = pend_r ? $signed(ram_rd_data) : top_val_r;
  assign stack_nonempty = (count_r != '0);
  assign stack_full     = (count_r == FULL_CNT);
  assign do_pop         = stack_nonempty && (cmp_val >= sample_r);
  assign count_dec      = count_r - CW'(1);
  assign push_addr      = stack_nonempty ? top_inc : base_r;
  assign out_free       = !out_valid_r || out_item.ready;

  assign in_item.ready       = (state_r == S_IDLE);
  assign out_item.valid      = out_valid_r;
  assign out_item.smaller_value = out_value_r;
  assign out_item.found      = out_found_r;
  assign out_item.overflowed = out_ovf_r;
  assign out_item.last_out   = out_last_r;

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    base_nxt      = base_r;
    top_ptr_nxt   = top_ptr_r;
    top_val_nxt   = top_val_r;
    pend_nxt      = pend_r;
    sample_nxt    = sample_r;
    last_nxt      = last_r;
    out_valid_nxt = out_valid_r && !out_item.ready;
    out_value_nxt = out_value_r;
    out_found_nxt = out_found_r;
    out_ovf_nxt   = out_ovf_r;
    out_last_nxt  = out_last_r;
    ram_wr_en     = 1'b0;
    ram_wr_addr   = push_addr;
    ram_rd_en     = 1'b0;
    ram_rd_addr   = top_dec;

    unique case (state_r)
      S_IDLE: begin
        if (in_item.valid) begin
          sample_nxt = in_item.sample_value;
          last_nxt   = in_item.end_of_sequence;
          state_nxt  = S_CMP;
        end
      end
      S_CMP: begin
        top_val_nxt = cmp_val;
        pend_nxt    = 1'b0;
        if (do_pop) begin
          // Drop the top; fetch the entry below it when one remains.
          count_nxt   = count_dec;
          top_ptr_nxt = top_dec;
          if (count_dec != '0) begin
            ram_rd_en = 1'b1;
            pend_nxt  = 1'b1;
          end
        end else if (out_free) begin
          // Report, push, and hand the result to the output register.
          out_valid_nxt = 1'b1;
          out_value_nxt = stack_nonempty ? cmp_val : '1;
          out_found_nxt = stack_nonempty;
          out_ovf_nxt   = stack_full;
          out_last_nxt  = last_r;
          ram_wr_en     = 1'b1;
          top_ptr_nxt   = push_addr;
          top_val_nxt   = sample_r;
          if (stack_full) begin
            base_nxt = base_inc;
          end
          if (last_r) begin
            count_nxt = '0;
          end else if (!stack_full) begin
            count_nxt = count_r + CW'(1);
          end
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      base_r      <= '0;
      top_ptr_r   <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      base_r      <= base_nxt;
      top_ptr_r   <= top_ptr_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    top_val_r   <= top_val_nxt;
    sample_r    <= sample_nxt;
    last_r      <= last_nxt;
    out_value_r <= out_value_nxt;
    out_found_r <= out_found_nxt;
    out_ovf_r   <= out_ovf_nxt;
    out_last_r  <= out_last_nxt;
  end

  // The fill count never passes the buffer depth.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= FULL_CNT)
    else $error("stack count above depth");

  // A pending RAM read only exists while entries remain.
  a_pend_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r |-> stack_nonempty)
    else $error("top fetch pending on empty stack");

  // An accepted item always moves to the compare step.
  a_accept_cmp: assert property (@(posedge clk) disable iff (!rst_n)
    (in_item.valid && in_item.ready) |=> (state_r == S_CMP))
    else $error("accepted item did not reach compare");

  // Overflow only happens with a full stack, so a smaller value exists.
  a_ovf_found: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_ovf_r) |-> out_found_r)
    else $error("overflow without found");

  // A result with end of sequence leaves the stack empty.
  a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
    ($rose(out_valid_r) && out_last_r) |-> (count_r == '0))
    else $error("stack not cleared after last item");

endmodule

>>> tb/sv/pss_prev_smaller_checker.sv
// Watches both channels, predicts each result from the samples and compares.
module pss_prev_smaller_checker #(
  parameter int unsigned STACK_DEPTH = pss_pkg::DEF_STACK_DEPTH,
  parameter int unsigned VALUE_WIDTH = pss_pkg::DEF_VALUE_WIDTH
) (
  input  logic        clk,
  input  logic        rst_n,
  pss_in_if           in_ch,
  pss_out_if          out_ch,
  output int unsigned mismatch_count,
  output int unsigned pending_count
);

  typedef struct packed {
    logic signed [VALUE_WIDTH-1:0] smaller_value;
    logic                          found;
    logic                          overflowed;
    logic                          last_out;
  } smaller_result_t;

  logic signed [VALUE_WIDTH-1:0] sample_history [STACK_DEPTH];
  int unsigned                   history_depth = 0;
  smaller_result_t               awaited_results [$];
  smaller_result_t               oldest_awaited;
  smaller_result_t               seen_result;
  int unsigned                   bad_count = 0;
  int unsigned                   awaited_count = 0;

  assign mismatch_count = bad_count;
  assign pending_count  = awaited_count;

  // Pop entries not strictly smaller, report the top, push, clear on last.
  function automatic smaller_result_t predict_smaller(
    input logic signed [VALUE_WIDTH-1:0] sample,
    input logic                          last_flag
  );
    smaller_result_t r;
    r.smaller_value = '1;
    r.found         = 1'b0;
    r.overflowed    = 1'b0;
    r.last_out      = last_flag;
    while (history_depth > 0 && sample_history[history_depth-1] >= sample)
      history_depth--;
    if (history_depth > 0) begin
      r.smaller_value = sample_history[history_depth-1];
      r.found         = 1'b1;
    end
    if (history_depth >= STACK_DEPTH) begin
      // full: drop the oldest entry
      for (int i = 0; i < STACK_DEPTH - 1; i++)
        sample_history[i] = sample_history[i+1];
      sample_history[STACK_DEPTH-1] = sample;
      r.overflowed = 1'b1;
    end else begin
      sample_history[history_depth] = sample;
      history_depth++;
    end
    if (last_flag)
      history_depth = 0;
    return r;
  endfunction

  task automatic compare_field(input string field, input logic signed [63:0] want,
                               input logic signed [63:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, field, want, got);
      bad_count++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      history_depth = 0;
      awaited_results.delete();
    end else begin
      // results first: one accepted in this edge cannot come from this edge's sample
      if (out_ch.valid && out_ch.ready) begin
        seen_result.smaller_value = out_ch.smaller_value;
        seen_result.found         = out_ch.found;
        seen_result.overflowed    = out_ch.overflowed;
        seen_result.last_out      = out_ch.last_out;
        if (awaited_results.size() == 0) begin
          $display("%0t: unexpected result: expected none, actual value %0d found %0b",
                   $time, seen_result.smaller_value, seen_result.found);
          bad_count++;
        end else begin
          oldest_awaited = awaited_results.pop_front();
          compare_field("smaller_value", oldest_awaited.smaller_value,
                        seen_result.smaller_value);
          compare_field("found", oldest_awaited.found, seen_result.found);
          compare_field("overflowed", oldest_awaited.overflowed, seen_result.overflowed);
          compare_field("last_out", oldest_awaited.last_out, seen_result.last_out);
        end
      end
      if (in_ch.valid && in_ch.ready)
        awaited_results.push_back(predict_smaller(in_ch.sample_value,
                                                  in_ch.end_of_sequence));
    end
    awaited_count = awaited_results.size();
  end

endmodule

>>> tb/sv/previous_smaller_stack_top_tb.sv
// Stimulus, idling and verdict for the previous-smaller-value stack block.
module previous_smaller_stack_top_tb;

  localparam int unsigned STACK_DEPTH = pss_pkg::DEF_STACK_DEPTH;
  localparam int unsigned VALUE_WIDTH = pss_pkg::DEF_VALUE_WIDTH;
  localparam int unsigned PHASE_ITEMS = 175;

  typedef enum int unsigned {
    SEQ_RISING,   // long climbing runs: fill the stack and overflow it
    SEQ_NARROW,   // a handful of values near zero: equal pops and real -1
    SEQ_NOISE,    // full-range values, sometimes left open into the next run
    SEQ_FALLING   // each sample pops everything before it
  } seq_kind_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  int unsigned send_idle_pct = 0;
  int unsigned stall_pct = 0;
  int unsigned mismatch_count;
  int unsigned pending_count;

  pss_in_if  #(.VALUE_WIDTH(VALUE_WIDTH)) in_ch ();
  pss_out_if #(.VALUE_WIDTH(VALUE_WIDTH)) out_ch ();

  previous_smaller_stack_top #(
    .STACK_DEPTH(STACK_DEPTH),
    .VALUE_WIDTH(VALUE_WIDTH)
  ) uut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_item (in_ch),
    .out_item(out_ch)
  );

  pss_prev_smaller_checker #(
    .STACK_DEPTH(STACK_DEPTH),
    .VALUE_WIDTH(VALUE_WIDTH)
  ) prev_smaller_chk (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_ch         (in_ch),
    .out_ch        (out_ch),
    .mismatch_count(mismatch_count),
    .pending_count (pending_count)
  );

  always #5 clk = ~clk;

  // Hard stop well past the slowest legal run.
  initial begin
    #2000000;
    $display("tb: failure");
    $finish;
  end

  // Receiver: decide ready at every falling edge; stall_pct sets how often it holds off.
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      out_ch.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Offer one sample. Enter and leave at a falling edge; valid stays high on exit,
  // so a back-to-back item is never lowered and raised in the same step.
  task automatic send_sample(input logic signed [VALUE_WIDTH-1:0] sample,
                             input logic last_flag);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid           <= 1'b1;
    in_ch.sample_value    <= sample;
    in_ch.end_of_sequence <= last_flag;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
  endtask

  // Hold the sender off until every predicted result has been seen.
  task automatic drain_results();
    in_ch.valid <= 1'b0;
    @(negedge clk);
    while (pending_count != 0) @(negedge clk);
  endtask

  // Send one random sequence of the given kind; return how many samples went out.
  task automatic send_sequence(input seq_kind_t kind, output int unsigned sent);
    int                            len;
    int                            start;
    int                            cur;
    logic signed [VALUE_WIDTH-1:0] sample;
    logic                          close;
    logic                          last_flag;
    sent  = 0;
    close = 1'b1;
    case (kind)
      SEQ_RISING: begin
        len   = $urandom_range(66, 95);
        start = int'($urandom_range(32'h8000_0000)) - 32'sh4000_0000;
        cur   = start;
      end
      SEQ_NARROW: begin
        len = $urandom_range(1, 30);
        cur = 0;
      end
      SEQ_NOISE: begin
        len   = $urandom_range(1, 12);
        close = ($urandom_range(9) != 0);
        cur   = 0;
      end
      default: begin
        len = $urandom_range(1, 20);
        cur = int'($urandom);
      end
    endcase
    for (int i = 0; i < len; i++) begin
      last_flag = close && (i == len - 1);
      case (kind)
        SEQ_RISING: begin
          if (i == len - 1) begin
            // below everything, or just above the start so a dropped entry
            // would have been the smaller value
            sample = $urandom_range(1) ? start - 1 : start + int'($urandom_range(1, 3000));
          end else if ($urandom_range(19) == 0) begin
            sample = cur - int'($urandom_range(0, 50));
          end else begin
            cur    = cur + int'($urandom_range(1, 1000));
            sample = cur;
          end
        end
        SEQ_NARROW:  sample = int'($urandom_range(8)) - 4;
        SEQ_NOISE:   sample = $urandom;
        default: begin
          cur    = cur - int'($urandom_range(0, 100000));
          sample = cur;
        end
      endcase
      send_sample(sample, last_flag);
      sent++;
    end
  endtask

  // One idling phase of random sequences, then drain.
  task automatic run_phase(input int unsigned idle, input int unsigned stall);
    int unsigned phase_sent;
    int unsigned sent;
    int unsigned pick;
    seq_kind_t   kind;
    send_idle_pct = idle;
    stall_pct     = stall;
    phase_sent    = 0;
    while (phase_sent < PHASE_ITEMS) begin
      pick = $urandom_range(99);
      if (pick < 30)      kind = SEQ_RISING;
      else if (pick < 60) kind = SEQ_NARROW;
      else if (pick < 85) kind = SEQ_NOISE;
      else                kind = SEQ_FALLING;
      send_sequence(kind, sent);
      phase_sent += sent;
    end
    drain_results();
  endtask

  initial begin
    in_ch.valid           = 1'b0;
    in_ch.sample_value    = '0;
    in_ch.end_of_sequence = 1'b0;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: extremes, equal values, a real -1 next to "none", sequence ends.
    send_sample(5, 1'b0);                      // first sample: nothing smaller
    send_sample(32'sh8000_0000, 1'b0);         // most negative pops all
    send_sample(32'sh7fff_ffff, 1'b0);         // most positive sees the minimum
    send_sample(-1, 1'b0);
    send_sample(0, 1'b0);                      // real -1 reported with found set
    send_sample(0, 1'b0);                      // equal value is popped
    send_sample(32'sh7fff_ffff, 1'b0);
    send_sample(32'sh8000_0000, 1'b1);         // end of sequence, nothing smaller
    send_sample(3, 1'b0);                      // fresh sequence after the clear
    send_sample(3, 1'b1);
    send_sample(-1, 1'b1);                     // single-sample sequence of -1
    send_sample(32'sh8000_0000, 1'b0);
    send_sample(32'sh8000_0000, 1'b0);         // equal minimum: nothing smaller
    send_sample(32'sh8000_0001, 1'b0);
    send_sample(32'sh7fff_fffe, 1'b0);
    send_sample(32'sh7fff_ffff, 1'b1);
    send_sample(32'sh5555_5555, 1'b0);
    send_sample(32'shAAAA_AAAA, 1'b0);
    send_sample(32'sh5555_5555, 1'b1);
    drain_results();

    run_phase(0, 0);
    run_phase(46, 0);
    run_phase(0, 46);
    run_phase(37, 37);

    in_ch.valid <= 1'b0;
    while (pending_count != 0) @(negedge clk);
    repeat (100) @(negedge clk);
    if (mismatch_count == 0 && pending_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
